// ===== rtl/core/spq_pkg.sv =====
// Package for the stable priority queue core.
// Holds widths, defaults, operation codes and the cell command struct.
// No dependencies.
`default_nettype none

package spq_pkg;

  // Field widths of the request and response items.
  localparam int unsigned PayloadW  = 16;
  localparam int unsigned PriorityW = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned OccW      = 5;

  // Default sizes for the top-level parameters.
  localparam int unsigned DefaultDepth        = 16;
  localparam int unsigned DefaultPayloadWidth = 16;

  // Operation codes carried in the kind field.
  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // Command broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_if.sv =====
// Valid/ready channel interfaces for the stable priority queue core.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [spq_pkg::KindW-1:0]             kind;
  logic [spq_pkg::PayloadW-1:0]          payload;
  logic signed [spq_pkg::PriorityW-1:0]  priority_req;

  modport source (output valid, kind, payload, priority_req, input ready);
  modport sink   (input valid, kind, payload, priority_req, output ready);
endinterface

interface spq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic [spq_pkg::PayloadW-1:0]          removed_payload;
  logic signed [spq_pkg::PriorityW-1:0]  removed_priority;
  logic                                  head_valid;
  logic [spq_pkg::PayloadW-1:0]          head_payload;
  logic signed [spq_pkg::PriorityW-1:0]  head_priority;
  logic [spq_pkg::OccW-1:0]              occupancy;

  modport source (output valid, ok, removed_payload, removed_priority, head_valid,
                  head_payload, head_priority, occupancy, input ready);
  modport sink   (input valid, ok, removed_payload, removed_priority, head_valid,
                  head_payload, head_priority, occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted shift chain: valid bit, priority and payload.
// Depends on spq_pkg for the command struct and priority width.
`default_nettype none

module spq_cell #(
  parameter int unsigned DATA_W = spq_pkg::DefaultPayloadWidth
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire spq_pkg::cell_cmd_t                cmd_i,
  input  wire signed [spq_pkg::PriorityW-1:0]    new_pri_i,
  input  wire        [DATA_W-1:0]                new_pay_i,
  // Neighbor toward the head.
  input  wire                                    left_stays_i,
  input  wire                                    left_valid_i,
  input  wire signed [spq_pkg::PriorityW-1:0]    left_pri_i,
  input  wire        [DATA_W-1:0]                left_pay_i,
  // Neighbor toward the tail.
  input  wire                                    right_valid_i,
  input  wire signed [spq_pkg::PriorityW-1:0]    right_pri_i,
  input  wire        [DATA_W-1:0]                right_pay_i,
  output logic                                   stays_o,
  output logic                                   valid_o,
  output logic signed [spq_pkg::PriorityW-1:0]   pri_o,
  output logic        [DATA_W-1:0]               pay_o
);

  logic                                  valid_q, valid_d;
  logic signed [spq_pkg::PriorityW-1:0]  pri_q, pri_d;
  logic [DATA_W-1:0]                     pay_q, pay_d;

  // An entry keeps its slot on insert when it ranks at or above the new one.
  assign stays_o = valid_q && (pri_q >= new_pri_i);

  // Next contents: keep, take the new entry, or shift from a neighbor.
  always_comb begin
    valid_d = valid_q;
    pri_d   = pri_q;
    pay_d   = pay_q;
    priority if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.insert) begin
      priority if (stays_o) begin
        valid_d = valid_q;
      end else if (left_stays_i) begin
        valid_d = 1'b1;
        pri_d   = new_pri_i;
        pay_d   = new_pay_i;
      end else begin
        valid_d = left_valid_i;
        pri_d   = left_pri_i;
        pay_d   = left_pay_i;
      end
    end else if (cmd_i.pop) begin
      valid_d = right_valid_i;
      pri_d   = right_pri_i;
      pay_d   = right_pay_i;
    end
  end

  // Only the valid bit is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    pay_q <= pay_d;
  end

  assign valid_o = valid_q;
  assign pri_o   = pri_q;
  assign pay_o   = pay_q;

endmodule

`default_nettype wire

// ===== rtl/core/stable_priority_queue_core.sv =====
// Stable priority queue: a chain of QUEUE_DEPTH cells kept sorted by priority.
// The response is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while the response is not stalled; each cell keeps, shifts or loads in that cycle.
// Reset clears all valid bits and the count; no clearing pass is needed.
// Depends on spq_pkg, spq_if and spq_cell.
`default_nettype none

module stable_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH   = spq_pkg::DefaultDepth,
  parameter int unsigned PAYLOAD_WIDTH = spq_pkg::DefaultPayloadWidth
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);

  localparam int unsigned StoreW = (PAYLOAD_WIDTH < spq_pkg::PayloadW) ?
                                   PAYLOAD_WIDTH : spq_pkg::PayloadW;
  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);

  logic                                 accept;
  logic                                 full;
  logic                                 empty;
  spq_pkg::cell_cmd_t                   cmd;
  logic [CountW-1:0]                    count_q, count_d;
  logic [StoreW-1:0]                    new_pay;

  logic [QUEUE_DEPTH-1:0]               stays;
  logic [QUEUE_DEPTH-1:0]               cvalid;
  logic signed [spq_pkg::PriorityW-1:0] cpri [QUEUE_DEPTH];
  logic [StoreW-1:0]                    cpay [QUEUE_DEPTH];

  logic                                 out_valid_q;
  logic                                 ok_q, ok_d;
  logic [spq_pkg::PayloadW-1:0]         rem_pay_q, rem_pay_d;
  logic signed [spq_pkg::PriorityW-1:0] rem_pri_q, rem_pri_d;

  // State only moves when the response register can take a new result.
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q == CountW'(QUEUE_DEPTH));
  assign empty       = (count_q == '0);
  assign new_pay     = req_i.payload[StoreW-1:0];

  // Decode the request into a chain command.
  always_comb begin
    cmd = '0;
    if (accept) begin
      unique case (req_i.kind)
        spq_pkg::KIND_INSERT: cmd.insert = !full;
        spq_pkg::KIND_REMOVE: cmd.pop    = !empty;
        spq_pkg::KIND_CLEAR:  cmd.clear  = 1'b1;
        default:              cmd        = '0;
      endcase
    end
  end

  // Entry count follows the command.
  always_comb begin
    count_d = count_q;
    priority if (cmd.clear) begin
      count_d = '0;
    end else if (cmd.insert) begin
      count_d = count_q + CountW'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CountW'(1);
    end
  end

  // Result of the request; removed fields come from the current head.
  always_comb begin
    ok_d      = cmd.insert || cmd.pop || cmd.clear;
    rem_pay_d = '0;
    rem_pri_d = '0;
    if (cmd.pop) begin
      rem_pay_d = spq_pkg::PayloadW'(cpay[0]);
      rem_pri_d = cpri[0];
    end
  end

  // The cell chain; the head cell takes a new entry directly.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                                 l_stays, l_valid, r_valid;
    logic signed [spq_pkg::PriorityW-1:0] l_pri, r_pri;
    logic [StoreW-1:0]                    l_pay, r_pay;

    if (i == 0) begin : g_head
      assign l_stays = 1'b1;
      assign l_valid = 1'b0;
      assign l_pri   = '0;
      assign l_pay   = '0;
    end else begin : g_body
      assign l_stays = stays[i-1];
      assign l_valid = cvalid[i-1];
      assign l_pri   = cpri[i-1];
      assign l_pay   = cpay[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_pri   = '0;
      assign r_pay   = '0;
    end else begin : g_inner
      assign r_valid = cvalid[i+1];
      assign r_pri   = cpri[i+1];
      assign r_pay   = cpay[i+1];
    end

    spq_cell #(
      .DATA_W(StoreW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_pri_i    (req_i.priority_req),
      .new_pay_i    (new_pay),
      .left_stays_i (l_stays),
      .left_valid_i (l_valid),
      .left_pri_i   (l_pri),
      .left_pay_i   (l_pay),
      .right_valid_i(r_valid),
      .right_pri_i  (r_pri),
      .right_pay_i  (r_pay),
      .stays_o      (stays[i]),
      .valid_o      (cvalid[i]),
      .pri_o        (cpri[i]),
      .pay_o        (cpay[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (req_i.ready) begin
        out_valid_q <= req_i.valid;
      end
    end
  end

  // Response payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q      <= ok_d;
      rem_pay_q <= rem_pay_d;
      rem_pri_q <= rem_pri_d;
    end
  end

  // Head and count are read live: they only change when a new result loads.
  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.ok               = ok_q;
  assign rsp_o.removed_payload  = rem_pay_q;
  assign rsp_o.removed_priority = rem_pri_q;
  assign rsp_o.head_valid       = cvalid[0];
  assign rsp_o.head_payload     = cvalid[0] ? spq_pkg::PayloadW'(cpay[0]) : '0;
  assign rsp_o.head_priority    = cvalid[0] ? cpri[0] : '0;
  assign rsp_o.occupancy        = spq_pkg::OccW'(count_q);

  // The head cell holds an entry exactly when the count is nonzero.
  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cvalid[0] == (count_q != '0))
    else $error("head valid disagrees with entry count");

  // The count never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // A remove from an empty queue reports failure and removes nothing.
  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.kind == spq_pkg::KIND_REMOVE && empty)
      |=> (!rsp_o.ok && rsp_o.removed_payload == '0 && !rsp_o.head_valid))
    else $error("remove from empty queue reported success");

  // An insert into a full queue leaves the count at the depth.
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.kind == spq_pkg::KIND_INSERT && full)
      |=> (!rsp_o.ok && count_q == CountW'(QUEUE_DEPTH)))
    else $error("insert into full queue changed the queue");

endmodule

`default_nettype wire
